// ===== design/mmpe_pkg.sv =====
// Shared types and constants for the matrix multiply and power engine.
`default_nettype none
package mmpe_pkg;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 6;
    localparam int DEPTH = 64;
    localparam int ACC_W = 72;

    typedef enum logic [1:0] {
        KIND_LOAD_A = 2'd0,
        KIND_LOAD_B = 2'd1,
        KIND_START  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        MODE_PRODUCT = 2'd0,
        MODE_POWER   = 2'd1,
        MODE_SCALE   = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    localparam logic [2:0] REG_ROWS     = 3'd0;
    localparam logic [2:0] REG_INNER    = 3'd1;
    localparam logic [2:0] REG_OUT_COLS = 3'd2;
    localparam logic [2:0] REG_MODE     = 3'd3;
    localparam logic [2:0] REG_EXPONENT = 3'd4;
    localparam logic [2:0] REG_SCALE    = 3'd5;

    // operand sources
    typedef enum logic [1:0] {
        SRC_A  = 2'd0,
        SRC_B  = 2'd1,
        SRC_W1 = 2'd2,
        SRC_W2 = 2'd3
    } src_t;

    // controller to datapath
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] x_addr;
        src_t              y_src;
        logic [ADDR_W-1:0] y_addr;
        logic              y_scalar;
        logic              acc_clear;
        logic              acc_en;
        logic              wr_en;
        logic              wr_w2;
        logic [ADDR_W-1:0] wr_addr;
    } dp_cmd_t;

    function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-17:0] s;
        t = acc + ACC_W'(32768);
        s = t[ACC_W-1:16];
        if (s > $signed((ACC_W-16)'(32'h7fffffff))) return 32'sh7fffffff;
        if (s < -$signed((ACC_W-16)'(33'h080000000))) return 32'sh80000000;
        return s[DATA_W-1:0];
    endfunction
endpackage
`default_nettype wire

// ===== design/mmpe_ram.sv =====
// Generic single-write, single-read RAM with registered read.
`default_nettype none
module mmpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== design/mmpe_datapath.sv =====
// Datapath: matrix stores, multiply-accumulate unit, rounding.
`default_nettype none
module mmpe_datapath import mmpe_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     ld_a,
    input  wire logic                     ld_b,
    input  wire logic [ADDR_W-1:0]        ld_addr,
    input  wire logic signed [DATA_W-1:0] ld_value,
    input  wire logic signed [DATA_W-1:0] scale_factor,
    input  wire dp_cmd_t                  cmd,
    input  wire logic                     out_sel_a,
    output logic signed [DATA_W-1:0]      rd_value
);
    logic [DATA_W-1:0] a_q, b_q, w1_q, w2_q, ax_q;
    logic signed [DATA_W-1:0] y_val, wr_data;
    logic signed [2*DATA_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [1:0] ysrc_reg;
    logic yscal_reg;
    logic ena_reg, enb_reg;
    logic w1_we, w2_we;

    // A is read twice: x operand and y/out operand
    mmpe_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_a_x (
        .aclk(aclk), .we(ld_a), .waddr(ld_addr), .wdata(ld_value),
        .raddr(cmd.x_addr), .rdata(ax_q));
    mmpe_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_a_y (
        .aclk(aclk), .we(ld_a), .waddr(ld_addr), .wdata(ld_value),
        .raddr(cmd.y_addr), .rdata(a_q));
    mmpe_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_b (
        .aclk(aclk), .we(ld_b), .waddr(ld_addr), .wdata(ld_value),
        .raddr(cmd.y_addr), .rdata(b_q));

    assign wr_data = round_sat(acc_reg);
    assign w1_we = cmd.wr_en && !cmd.wr_w2;
    assign w2_we = cmd.wr_en && cmd.wr_w2;

    mmpe_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_w1 (
        .aclk(aclk), .we(w1_we), .waddr(cmd.wr_addr), .wdata(wr_data),
        .raddr(cmd.y_addr), .rdata(w1_q));
    mmpe_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_w2 (
        .aclk(aclk), .we(w2_we), .waddr(cmd.wr_addr), .wdata(wr_data),
        .raddr(cmd.y_addr), .rdata(w2_q));

    always_comb begin
        case (src_t'(ysrc_reg))
            SRC_A:   y_val = a_q;
            SRC_B:   y_val = b_q;
            SRC_W1:  y_val = w1_q;
            default: y_val = w2_q;
        endcase
        if (yscal_reg) y_val = scale_factor;
    end

    assign rd_value = out_sel_a ? a_q : y_val;

    // stage 1: read, stage 2: multiply, stage 3: accumulate
    always_ff @(posedge aclk) begin
        ysrc_reg  <= cmd.y_src;
        yscal_reg <= cmd.y_scalar;
        ena_reg   <= cmd.acc_en;
        enb_reg   <= ena_reg;
        prod_reg  <= $signed(ax_q) * y_val;
        if (cmd.acc_clear) acc_reg <= '0;
        else if (enb_reg) acc_reg <= acc_reg + ACC_W'(prod_reg);
    end
endmodule
`default_nettype wire

// ===== design/mmpe_controller.sv =====
// Controller: sequences multiply passes and result readout.
`default_nettype none
module mmpe_controller import mmpe_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire mode_t             mode,
    input  wire logic [3:0]        nr,
    input  wire logic [3:0]        nk,
    input  wire logic [3:0]        nc,
    input  wire logic [5:0]        exponent,
    input  wire logic              out_ready,
    output logic                   busy,
    output dp_cmd_t                cmd,
    output logic                   out_sel_a,
    output logic                   out_valid,
    output logic [ADDR_W-1:0]      out_index,
    output logic                   out_last,
    output logic                   out_take
);
    typedef enum logic [2:0] {S_IDLE, S_MAC, S_DRAIN, S_WRITE, S_OUT, S_WAIT} state_t;
    state_t state_reg;
    logic [3:0] r_reg, c_reg, k_reg, dr_reg, dk_reg, dc_reg;
    logic [5:0] pass_reg, passes_reg;
    logic [2:0] drain_reg;
    logic scale_reg, fsrc_reg, dst2_reg, osel_reg;
    src_t osrc_reg;
    logic [6:0] oi_reg, cnt_reg;
    logic [7:0] xa, ya;
    logic       fetch;
    logic [1:0] pend_reg;

    assign busy = state_reg != S_IDLE;
    assign xa = scale_reg ? {1'b0, oi_reg} : 8'(r_reg) * 8'(dk_reg) + 8'(k_reg);
    assign ya = 8'(k_reg) * 8'(dc_reg) + 8'(c_reg);
    assign fetch = state_reg == S_OUT && pend_reg == 2'd0 && !out_valid;
    assign out_take = out_valid && out_ready;

    always_comb begin
        cmd = '0;
        cmd.y_scalar = scale_reg;
        cmd.wr_w2 = dst2_reg;
        cmd.wr_addr = scale_reg ? oi_reg[5:0] : 6'(8'(r_reg) * 8'(dc_reg) + 8'(c_reg));
        if (fsrc_reg) cmd.y_src = pass_reg[0] ? SRC_W2 : SRC_W1;
        else cmd.y_src = (mode == MODE_PRODUCT) ? SRC_B : SRC_A;
        cmd.x_addr = xa[5:0];
        cmd.y_addr = ya[5:0];
        case (state_reg)
            S_IDLE:  cmd.acc_clear = 1'b1;
            S_MAC:   cmd.acc_en = 1'b1;
            S_WRITE: begin
                cmd.wr_en = 1'b1;
                cmd.acc_clear = 1'b1;
            end
            S_OUT: begin
                cmd.y_src = osrc_reg;
                cmd.y_scalar = 1'b0;
                cmd.y_addr = oi_reg[5:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_valid <= 1'b0;
            pend_reg  <= '0;
        end else begin
            if (out_take) out_valid <= 1'b0;
            case (state_reg)
                S_IDLE: if (start && mode != MODE_NONE) begin
                    r_reg <= '0; c_reg <= '0; k_reg <= '0; oi_reg <= '0;
                    pass_reg <= 6'd1; fsrc_reg <= 1'b0; dst2_reg <= 1'b0;
                    scale_reg <= mode == MODE_SCALE;
                    osel_reg <= 1'b0;
                    dr_reg <= nr;
                    passes_reg <= exponent;
                    case (mode)
                        MODE_PRODUCT: begin
                            dk_reg <= nk; dc_reg <= nc;
                            cnt_reg <= 7'(nr) * 7'(nc); osrc_reg <= SRC_W1;
                            state_reg <= S_MAC;
                        end
                        MODE_SCALE: begin
                            dk_reg <= nk; dc_reg <= nk;
                            cnt_reg <= 7'(nr) * 7'(nk); osrc_reg <= SRC_W1;
                            state_reg <= S_MAC;
                        end
                        default: begin
                            dk_reg <= nr; dc_reg <= nr;
                            cnt_reg <= 7'(nr) * 7'(nr);
                            osrc_reg <= exponent[0] ? SRC_W2 : SRC_W1;
                            if (exponent <= 6'd1) begin
                                osel_reg <= 1'b1;
                                state_reg <= S_OUT;
                            end else state_reg <= S_MAC;
                        end
                    endcase
                end
                S_MAC: begin
                    if (scale_reg || k_reg == dk_reg - 4'd1) begin
                        drain_reg <= 3'd3;
                        state_reg <= S_DRAIN;
                    end else k_reg <= k_reg + 4'd1;
                end
                S_DRAIN: begin
                    drain_reg <= drain_reg - 3'd1;
                    if (drain_reg == 3'd1) state_reg <= S_WRITE;
                end
                S_WRITE: begin
                    k_reg <= '0;
                    oi_reg <= oi_reg + 7'd1;
                    state_reg <= S_MAC;
                    if (scale_reg) begin
                        if (oi_reg + 7'd1 == cnt_reg) begin
                            oi_reg <= '0; state_reg <= S_OUT;
                        end
                    end else if (c_reg != dc_reg - 4'd1) c_reg <= c_reg + 4'd1;
                    else begin
                        c_reg <= '0;
                        if (r_reg != dr_reg - 4'd1) r_reg <= r_reg + 4'd1;
                        else begin
                            r_reg <= '0;
                            if (mode != MODE_POWER || pass_reg + 6'd1 >= passes_reg) begin
                                oi_reg <= '0; state_reg <= S_OUT;
                            end else begin
                                pass_reg <= pass_reg + 6'd1;
                                fsrc_reg <= 1'b1;
                                dst2_reg <= pass_reg[0];
                            end
                        end
                    end
                end
                S_OUT: begin
                    pend_reg <= {pend_reg[0], fetch};
                    if (pend_reg[1]) begin
                        out_valid <= 1'b1;
                        out_index <= oi_reg[5:0];
                        out_last <= oi_reg + 7'd1 == cnt_reg;
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT: if (out_take) begin
                    pend_reg <= '0;
                    if (out_last) state_reg <= S_IDLE;
                    else begin
                        oi_reg <= oi_reg + 7'd1;
                        state_reg <= S_OUT;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_sel_a = osel_reg;

    property p_last_ends;
        @(posedge aclk) disable iff (!aresetn) (out_take && out_last) |=> state_reg == S_IDLE;
    endproperty
    a_last_ends: assert property (p_last_ends) else $error("run did not end after last");
    a_no_write_out: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> !cmd.wr_en) else $error("write during readout");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> out_valid && $stable(out_index))
        else $error("result dropped");
endmodule
`default_nettype wire

// ===== design/matrix_multiply_power_engine.sv =====
// Top level of the matrix multiply, power and scale engine.
// A product pass computes nr*nc elements of nk terms each; power mode runs (exponent-1)
// passes and scale mode one pass over the elements, all on the single MAC; the result
// elements are then read out through the store read ports.
// One item at a time; s_axis_tready is low while a start is running.
// aresetn (synchronous, active low) restores register defaults; stores are not cleared.
`default_nettype none
module matrix_multiply_power_engine import mmpe_pkg::*; #(
    parameter int MAX_DIM = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // elem_index[5:0], elem_value[37:6]
    input  wire logic [1:0]  s_axis_tuser,  // kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // res_value[31:0], res_index[37:32]
    output logic             m_axis_tlast,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam logic [3:0] CAP = 4'((MAX_DIM < 8) ? MAX_DIM : 8);
    logic [3:0] rows_reg, inner_reg, cols_reg;
    logic [1:0] mode_reg;
    logic [5:0] exp_reg;
    logic signed [31:0] scale_reg;
    logic busy, acc, sel_a;
    dp_cmd_t cmd;
    logic [5:0] oidx;
    logic signed [31:0] rval;
    logic take;

    function automatic logic [3:0] clampd(input logic [3:0] d);
        if (d == 4'd0) return 4'd1;
        if (d > CAP) return CAP;
        return d;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= 4'd1; inner_reg <= 4'd1; cols_reg <= 4'd1;
            mode_reg <= MODE_PRODUCT; exp_reg <= 6'd1; scale_reg <= 32'sd65536;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ROWS:     rows_reg <= cfg_data[3:0];
                REG_INNER:    inner_reg <= cfg_data[3:0];
                REG_OUT_COLS: cols_reg <= cfg_data[3:0];
                REG_MODE:     mode_reg <= cfg_data[1:0];
                REG_EXPONENT: exp_reg <= cfg_data[5:0];
                REG_SCALE:    scale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !busy;
    assign acc = s_axis_tvalid && s_axis_tready;

    mmpe_controller u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .start(acc && s_axis_tuser == KIND_START), .mode(mode_t'(mode_reg)),
        .nr(clampd(rows_reg)), .nk(clampd(inner_reg)), .nc(clampd(cols_reg)),
        .exponent(exp_reg), .out_ready(m_axis_tready), .busy(busy), .cmd(cmd),
        .out_sel_a(sel_a), .out_valid(m_axis_tvalid), .out_index(oidx),
        .out_last(m_axis_tlast), .out_take(take));

    mmpe_datapath u_dp (
        .aclk(aclk),
        .ld_a(acc && s_axis_tuser == KIND_LOAD_A),
        .ld_b(acc && s_axis_tuser == KIND_LOAD_B),
        .ld_addr(s_axis_tdata[5:0]), .ld_value(s_axis_tdata[37:6]),
        .scale_factor(scale_reg), .cmd(cmd), .out_sel_a(sel_a), .rd_value(rval));

    logic [31:0] hold_reg;
    logic pv_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) pv_reg <= 1'b0;
        else pv_reg <= m_axis_tvalid;
        if (m_axis_tvalid && !pv_reg) hold_reg <= rval;
    end
    assign m_axis_tdata = {2'b00, oidx, (pv_reg ? hold_reg : rval)};

    a_take_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        take |-> m_axis_tvalid) else $error("take without valid");
endmodule
`default_nettype wire

// ===== sim/tb_matrix_multiply_power_engine.sv =====
// Testbench for the matrix multiply, power and scale engine: predicted results checked per transaction.
`timescale 1ns / 100ps
`default_nettype none
module tb_matrix_multiply_power_engine import mmpe_pkg::*;;

    localparam int STALL_LIMIT = 200000;

    class mmpe_scoreboard;
        logic signed [31:0] mat_a [64];
        logic signed [31:0] mat_b [64];
        logic signed [31:0] work1 [64];
        logic signed [31:0] work2 [64];
        logic [3:0]         n_rows, n_inner, n_cols;
        logic [5:0]         n_exp;
        mode_t              op_mode;
        logic signed [31:0] scale;
        logic [31:0]        want_value [$];
        logic [5:0]         want_index [$];
        bit                 want_last [$];
        int                 errors, n_results, n_starts, n_loads;

        function new();
            n_rows = 1; n_inner = 1; n_cols = 1; op_mode = MODE_PRODUCT;
            n_exp = 1; scale = 32'sd65536;
            foreach (mat_a[i]) begin
                mat_a[i] = 0; mat_b[i] = 0; work1[i] = 0; work2[i] = 0;
            end
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] d);
            case (idx)
                REG_ROWS:     n_rows = d[3:0];
                REG_INNER:    n_inner = d[3:0];
                REG_OUT_COLS: n_cols = d[3:0];
                REG_MODE:     op_mode = mode_t'(d[1:0]);
                REG_EXPONENT: n_exp = d[5:0];
                REG_SCALE:    scale = d;
                default: ;
            endcase
        endfunction

        function int unsigned clamp(logic [3:0] d);
            if (d == 0) return 1;
            if (d > 8) return 8;
            return d;
        endfunction

        function logic signed [31:0] rd(src_t s, int unsigned i);
            case (s)
                SRC_A:   return mat_a[i & 63];
                SRC_B:   return mat_b[i & 63];
                SRC_W1:  return work1[i & 63];
                default: return work2[i & 63];
            endcase
        endfunction

        function logic signed [31:0] round_sat(logic signed [127:0] acc);
            logic signed [127:0] t;
            t = (acc + 128'sd32768) >>> 16;
            if (t > 128'sh7fffffff) return 32'h7fffffff;
            if (t < -128'sh80000000) return 32'h80000000;
            return t[31:0];
        endfunction

        function void mat_mul(src_t dst, src_t x, int unsigned xs, src_t y, int unsigned ys,
                              int unsigned nr, int unsigned nk, int unsigned nc);
            logic signed [127:0] acc, px, py;
            logic signed [31:0]  v;
            for (int unsigned r = 0; r < nr; r++)
                for (int unsigned c = 0; c < nc; c++) begin
                    acc = 0;
                    for (int unsigned k = 0; k < nk; k++) begin
                        px = rd(x, r * xs + k);
                        py = rd(y, k * ys + c);
                        acc = acc + px * py;
                    end
                    v = round_sat(acc);
                    if (dst == SRC_W1) work1[(r * nc + c) & 63] = v;
                    else work2[(r * nc + c) & 63] = v;
                end
        endfunction

        function void note_input(kind_t k, logic [5:0] idx, logic [31:0] val);
            int unsigned nr, nk, nc, cnt, p;
            src_t res, srcm, dstm;
            logic signed [127:0] px, py;
            nr = clamp(n_rows); nk = clamp(n_inner); nc = clamp(n_cols);
            case (k)
                KIND_LOAD_A: begin mat_a[idx] = val; n_loads++; return; end
                KIND_LOAD_B: begin mat_b[idx] = val; n_loads++; return; end
                KIND_START: ;
                default: return;
            endcase
            case (op_mode)
                MODE_PRODUCT: begin
                    mat_mul(SRC_W1, SRC_A, nk, SRC_B, nc, nr, nk, nc);
                    res = SRC_W1;
                    cnt = nr * nc;
                end
                MODE_POWER: begin
                    p = n_exp;
                    cnt = nr * nr;
                    res = SRC_A;
                    if (p > 1) begin
                        for (int unsigned j = 1; j < p; j++) begin
                            srcm = (j == 1) ? SRC_A : ((j & 1) ? SRC_W2 : SRC_W1);
                            dstm = (j & 1) ? SRC_W1 : SRC_W2;
                            mat_mul(dstm, SRC_A, nr, srcm, nr, nr, nr, nr);
                        end
                        res = (p & 1) ? SRC_W2 : SRC_W1;
                    end
                end
                MODE_SCALE: begin
                    cnt = nr * nk;
                    for (int unsigned i = 0; i < cnt; i++) begin
                        px = mat_a[i & 63];
                        py = scale;
                        work1[i & 63] = round_sat(px * py);
                    end
                    res = SRC_W1;
                end
                default: return;
            endcase
            n_starts++;
            for (int unsigned i = 0; i < cnt; i++) begin
                want_value.push_back(rd(res, i));
                want_index.push_back(6'(i));
                want_last.push_back(i + 1 == cnt);
            end
        endfunction

        function void check_result(logic [31:0] val, logic [5:0] idx, bit last);
            n_results++;
            if (want_value.size() == 0) begin
                $display("%0t: unexpected result value=%h index=%0d last=%0b",
                         $time, val, idx, last);
                errors++;
                return;
            end
            if (val !== want_value[0] || idx !== want_index[0] || last !== want_last[0]) begin
                $display("%0t: expected value=%h index=%0d last=%0b, got value=%h index=%0d last=%0b",
                         $time, want_value[0], want_index[0], want_last[0], val, idx, last);
                errors++;
            end
            void'(want_value.pop_front());
            void'(want_index.pop_front());
            void'(want_last.pop_front());
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    mmpe_scoreboard sb;
    int sender_idle;
    int recv_stall;
    int quiet_cycles;

    matrix_multiply_power_engine u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[31:0], m_axis_tdata[37:32], m_axis_tlast);
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2, 3: return 32'($signed($urandom_range(262144)) - 131072);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(kind_t k, logic [5:0] idx, logic [31:0] val);
        if ($urandom_range(99) < sender_idle) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= k;
        s_axis_tdata  <= {2'b00, val, idx};
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_input(k, idx, val);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.want_value.size() != 0 || !s_axis_tready);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_config(logic [3:0] r, logic [3:0] i, logic [3:0] c, mode_t m,
                              logic [5:0] e, logic [31:0] s);
        logic [31:0] vals [6];
        wait_idle();
        vals = '{32'(r), 32'(i), 32'(c), 32'(m), 32'(e), s};
        for (int n = 0; n < 6; n++) begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(n);
            cfg_data  <= vals[n];
            @(posedge aclk);
            sb.set_reg(3'(n), vals[n]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic config_and_start(logic [3:0] r, logic [3:0] i, logic [3:0] c, mode_t m,
                                    logic [5:0] e, logic [31:0] s);
        set_config(r, i, c, m, e, s);
        send_item(KIND_START, 6'($urandom), $urandom);
    endtask

    task automatic run_phase(int n_items);
        int roll;
        for (int n = 0; n < n_items; n++) begin
            roll = $urandom_range(99);
            if (roll < 10)
                send_item(KIND_START, 6'($urandom), $urandom);
            else if (roll < 13)
                send_item(KIND_NONE, 6'($urandom), $urandom);
            else
                send_item(roll[0] ? KIND_LOAD_A : KIND_LOAD_B, 6'($urandom), pick_value());
        end
    endtask

    task automatic random_config();
        logic [3:0] r, i, c;
        mode_t      m;
        logic [5:0] e;
        logic [31:0] s;
        r = ($urandom_range(4) == 0) ? 4'($urandom) : 4'($urandom_range(1, 4));
        i = ($urandom_range(4) == 0) ? 4'($urandom) : 4'($urandom_range(1, 4));
        c = ($urandom_range(4) == 0) ? 4'($urandom) : 4'($urandom_range(1, 4));
        m = ($urandom_range(11) == 0) ? MODE_NONE : mode_t'($urandom_range(2));
        e = 6'($urandom_range(5));
        if (m == MODE_POWER && $urandom_range(9) == 0) begin
            e = 6'($urandom);
            r = 4'($urandom_range(1, 3));
        end
        s = ($urandom_range(3) == 0) ? pick_value() : 32'($signed($urandom_range(262144)) - 131072);
        set_config(r, i, c, m, e, s);
    endtask

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = KIND_LOAD_A;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_ROWS;
        cfg_data = '0;
        sender_idle = 0;
        recv_stall = 0;
        quiet_cycles = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every entry written before any read
        for (int n = 0; n < 64; n++) send_item(KIND_LOAD_A, 6'(n), pick_value());
        for (int n = 0; n < 64; n++) send_item(KIND_LOAD_B, 6'(n), pick_value());

        // directed: extremes, each mode, clamped sizes, ignored items
        send_item(KIND_START, 6'd0, 32'd0);
        send_item(KIND_LOAD_A, 6'd0, 32'h80000000);
        send_item(KIND_LOAD_A, 6'd63, 32'h7fffffff);
        send_item(KIND_LOAD_B, 6'd0, 32'h80000000);
        send_item(KIND_LOAD_B, 6'd63, 32'h7fffffff);
        send_item(KIND_NONE, 6'd63, 32'hffffffff);
        config_and_start(4'd8, 4'd8, 4'd8, MODE_PRODUCT, 6'd1, 32'h00010000);
        config_and_start(4'd15, 4'd0, 4'd15, MODE_PRODUCT, 6'd1, 32'h00010000);
        config_and_start(4'd8, 4'd8, 4'd1, MODE_SCALE, 6'd0, 32'h80000000);
        config_and_start(4'd8, 4'd8, 4'd1, MODE_SCALE, 6'd0, 32'h7fffffff);
        config_and_start(4'd8, 4'd3, 4'd2, MODE_POWER, 6'd0, 32'h0);
        config_and_start(4'd3, 4'd1, 4'd2, MODE_POWER, 6'd1, 32'h0);
        config_and_start(4'd0, 4'd5, 4'd2, MODE_POWER, 6'd2, 32'h0);
        config_and_start(4'd8, 4'd8, 4'd8, MODE_POWER, 6'd63, 32'h0);
        config_and_start(4'd2, 4'd2, 4'd2, MODE_NONE, 6'd3, 32'h0);
        send_item(KIND_LOAD_A, 6'd21, 32'h00010000);

        for (int ph = 0; ph < 18; ph++) begin
            random_config();
            case (ph % 4)
                0: begin sender_idle = 0;  recv_stall = 0;  end
                1: begin sender_idle = 69; recv_stall = 0;  end
                2: begin sender_idle = 0;  recv_stall = 69; end
                default: begin sender_idle = 25; recv_stall = 25; end
            endcase
            run_phase(18);
        end

        wait_idle();
        repeat (50) @(posedge aclk);
        $display("covered %0d loads and %0d computations (product, power, scale) over varied sizes",
                 sb.n_loads, sb.n_starts);
        $display("checked %0d result elements under several idle and stall patterns", sb.n_results);
        if (sb.errors == 0 && sb.want_value.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
